// File: rtl/core/cal_pkg.sv
package cal_pkg;

  // List geometry
  localparam int CAPACITY   = 512;
  localparam int DATA_WIDTH = 32;

  // Port widths fixed by the item format
  localparam int FUNC_W  = 4;
  localparam int ELEM_W  = 32;
  localparam int COUNT_W = 10;
  localparam int POS_W   = 10;

  // Internal count and cursor width, and a width wide enough to compare either against a port
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WIDE_W = 16;

  // Read tree: OR of one-hot masked cell words, eight children per node
  localparam int TREE_RADIX = 8;

  function automatic int tree_levels(input int leaves);
    int lv;
    int span;
    lv   = 1;
    span = TREE_RADIX;
    while (span < leaves) begin
      span = span * TREE_RADIX;
      lv++;
    end
    return lv;
  endfunction

  localparam int TREE_LEVELS = tree_levels(CAPACITY);
  localparam int TREE_PAD    = TREE_RADIX ** TREE_LEVELS;
  localparam int WAIT_W      = $clog2(TREE_LEVELS + 1);

  // Number of nodes on a tree level, level 0 being nearest the leaves
  function automatic int tree_width(input int lvl);
    return TREE_RADIX ** (TREE_LEVELS - 1 - lvl);
  endfunction

  // Offset of a tree level in the flat node store
  function automatic int tree_off(input int lvl);
    int sum;
    sum = 0;
    for (int k = 0; k < lvl; k++) begin
      sum = sum + tree_width(k);
    end
    return sum;
  endfunction

  localparam int TREE_NODES = tree_off(TREE_LEVELS);

  // Operation codes of the func field
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 4'd0,
    FN_APPEND = 4'd1,
    FN_REMOVE = 4'd2,
    FN_BEGIN  = 4'd3,
    FN_END    = 4'd4,
    FN_PREV   = 4'd5,
    FN_NEXT   = 4'd6,
    FN_SET    = 4'd7,
    FN_CLEAR  = 4'd8,
    FN_READ   = 4'd9
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOELEM = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  // Shift command broadcast to every cell
  typedef enum logic [1:0] {
    CO_HOLD   = 2'd0,
    CO_INSERT = 2'd1,
    CO_APPEND = 2'd2,
    CO_REMOVE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [CNT_W-1:0]      cursor;
    logic [CNT_W-1:0]      length;
    logic [DATA_WIDTH-1:0] data;
  } cell_cmd_t;

endpackage

// File: rtl/core/cal_cell.sv
module cal_cell
  import cal_pkg::*;
(
  input  logic                  clk,
  input  logic [CNT_W-1:0]      index,
  input  cell_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] read_data
);

  // Shift up on insert, down on remove, load on the write place
  always_ff @(posedge clk) begin
    case (cmd.op)
      CO_INSERT: begin
        if (index == cmd.cursor) begin
          data <= cmd.data;
        end else if (index > cmd.cursor) begin
          data <= left_data;
        end
      end
      CO_APPEND: begin
        if (index == cmd.length) begin
          data <= cmd.data;
        end
      end
      CO_REMOVE: begin
        if (index >= cmd.cursor) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

  // Offer the word to the read tree only at the cursor
  assign read_data = (index == cmd.cursor) ? data : '0;

endmodule

// File: rtl/core/cal_read_tree.sv
module cal_read_tree
  import cal_pkg::*;
(
  input  logic                  clk,
  input  logic [DATA_WIDTH-1:0] leaf [CAPACITY],
  output logic [DATA_WIDTH-1:0] root
);

  logic [DATA_WIDTH-1:0] leaf_pad [TREE_PAD];
  logic [DATA_WIDTH-1:0] node_in  [TREE_NODES];
  logic [DATA_WIDTH-1:0] node     [TREE_NODES];

  // Pad the leaves up to a full tree with zeros
  for (genvar i = 0; i < TREE_PAD; i++) begin : g_pad
    if (i < CAPACITY) begin : g_real
      assign leaf_pad[i] = leaf[i];
    end else begin : g_zero
      assign leaf_pad[i] = '0;
    end
  end

  // OR eight children into each node
  for (genvar l = 0; l < TREE_LEVELS; l++) begin : g_lvl
    for (genvar j = 0; j < tree_width(l); j++) begin : g_node
      logic [DATA_WIDTH-1:0] sum;
      if (l == 0) begin : g_leaf
        always_comb begin
          sum = '0;
          for (int k = 0; k < TREE_RADIX; k++) begin
            sum = sum | leaf_pad[j * TREE_RADIX + k];
          end
        end
      end else begin : g_inner
        always_comb begin
          sum = '0;
          for (int k = 0; k < TREE_RADIX; k++) begin
            sum = sum | node[tree_off(l - 1) + j * TREE_RADIX + k];
          end
        end
      end
      assign node_in[tree_off(l) + j] = sum;
    end
  end

  // Register every level
  always_ff @(posedge clk) begin
    node <= node_in;
  end

  assign root = node[TREE_NODES - 1];

endmodule

// File: rtl/core/cursor_array_list.sv
// Channel  Handshake             Payload
// in       in_valid / in_ready   func, value, position
// out      out_valid / out_ready element, count, cursor, status
//
// Items may follow back to back while the output is not stalled, unless an item is a remove
// or read current that finds an element.
// Remove and read current that find an element hold back the next item while the word at the
// cursor climbs a registered OR tree of radix 8 over the cells before it is reported.
// Shifts happen in the accept cycle: each cell loads from its neighbour in one step.
// Reset clears count, cursor and the handshake state; stored entries stay as they are.
// A result waits in the output register while the next item is taken; one more is held behind it.
module cursor_array_list
  import cal_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FUNC_W-1:0]        func,
  input  logic signed [ELEM_W-1:0] value,
  input  logic [POS_W-1:0]         position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ELEM_W-1:0] element,
  output logic [COUNT_W-1:0]       count,
  output logic [COUNT_W-1:0]       cursor,
  output logic [1:0]               status
);

  logic [CNT_W-1:0]      length;
  logic [CNT_W-1:0]      cursor_pos;
  logic [CNT_W-1:0]      length_next;
  logic [CNT_W-1:0]      cursor_next;
  status_t               status_next;
  cell_op_t              op_next;
  logic                  needs_read;
  logic                  list_full;
  logic                  at_end;
  logic                  accept;
  logic                  move;
  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] chain     [CAPACITY + 2];
  logic [DATA_WIDTH-1:0] read_word [CAPACITY];
  logic [DATA_WIDTH-1:0] root;

  logic                  pend_valid;
  logic [WAIT_W-1:0]     pend_wait;
  logic [CNT_W-1:0]      pend_count;
  logic [CNT_W-1:0]      pend_cursor;
  status_t               pend_status;
  logic [DATA_WIDTH-1:0] pend_elem;
  status_t               out_status;

  assign list_full = (length == CNT_W'(CAPACITY));
  assign at_end    = (cursor_pos == length);

  // Decode the operation against the current count and cursor
  always_comb begin
    length_next = length;
    cursor_next = cursor_pos;
    status_next = ST_OK;
    op_next     = CO_HOLD;
    needs_read  = 1'b0;
    unique case (func_t'(func))
      FN_INSERT: begin
        if (list_full) begin
          status_next = ST_FULL;
        end else begin
          op_next     = CO_INSERT;
          length_next = length + CNT_W'(1);
        end
      end
      FN_APPEND: begin
        if (list_full) begin
          status_next = ST_FULL;
        end else begin
          op_next     = CO_APPEND;
          length_next = length + CNT_W'(1);
        end
      end
      FN_REMOVE: begin
        if (at_end) begin
          status_next = ST_NOELEM;
        end else begin
          op_next     = CO_REMOVE;
          needs_read  = 1'b1;
          length_next = length - CNT_W'(1);
        end
      end
      FN_BEGIN: cursor_next = '0;
      FN_END:   cursor_next = length;
      FN_PREV: begin
        if (cursor_pos != '0) begin
          cursor_next = cursor_pos - CNT_W'(1);
        end
      end
      FN_NEXT: begin
        if (!at_end) begin
          cursor_next = cursor_pos + CNT_W'(1);
        end
      end
      FN_SET: begin
        if (WIDE_W'(position) > WIDE_W'(length)) begin
          status_next = ST_RANGE;
        end else begin
          cursor_next = CNT_W'(position);
        end
      end
      FN_CLEAR: begin
        length_next = '0;
        cursor_next = '0;
      end
      FN_READ: begin
        if (at_end) begin
          status_next = ST_NOELEM;
        end else begin
          needs_read = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Handshake
  assign move     = pend_valid && (pend_wait == '0) && (!out_valid || out_ready);
  assign in_ready = !pend_valid || move;
  assign accept   = in_valid && in_ready;

  // Broadcast the shift command to the row
  assign cmd.op     = accept ? op_next : CO_HOLD;
  assign cmd.cursor = cursor_pos;
  assign cmd.length = length;
  assign cmd.data   = DATA_WIDTH'(value);

  // Row of cells, zero words at both ends of the chain
  assign chain[0]            = '0;
  assign chain[CAPACITY + 1] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cal_cell u_cell (
      .clk        (clk),
      .index      (CNT_W'(i)),
      .cmd        (cmd),
      .left_data  (chain[i]),
      .right_data (chain[i + 2]),
      .data       (chain[i + 1]),
      .read_data  (read_word[i])
    );
  end

  cal_read_tree u_read_tree (
    .clk  (clk),
    .leaf (read_word),
    .root (root)
  );

  // Count, cursor and handshake control
  always_ff @(posedge clk) begin
    if (rst) begin
      length     <= '0;
      cursor_pos <= '0;
      pend_valid <= 1'b0;
      pend_wait  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        length     <= length_next;
        cursor_pos <= cursor_next;
        pend_valid <= 1'b1;
        pend_wait  <= needs_read ? WAIT_W'(TREE_LEVELS) : '0;
      end else begin
        if (move) begin
          pend_valid <= 1'b0;
        end
        if (pend_wait != '0) begin
          pend_wait <= pend_wait - WAIT_W'(1);
        end
      end
    end
  end

  // Pending result, then output register
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_count  <= length_next;
      pend_cursor <= cursor_next;
      pend_status <= status_next;
      pend_elem   <= '0;
    end else if (pend_wait == WAIT_W'(1)) begin
      pend_elem <= root;
    end
    if (move) begin
      element    <= ELEM_W'(pend_elem);
      count      <= COUNT_W'(pend_count);
      cursor     <= COUNT_W'(pend_cursor);
      out_status <= pend_status;
    end
  end

  assign status = out_status;

  // Cursor never passes the end of the list
  a_cursor_in_list: assert property (@(posedge clk) disable iff (rst)
    cursor_pos <= length) else $error("cursor beyond list end");

  // Count never exceeds the row of cells
  a_length_cap: assert property (@(posedge clk) disable iff (rst)
    length <= CNT_W'(CAPACITY)) else $error("count beyond capacity");

  // No item is taken while a read climbs the tree
  a_wait_blocks: assert property (@(posedge clk) disable iff (rst)
    pend_wait != '0 |-> pend_valid && !in_ready) else $error("item taken during read");

  // A read result is latched from the tree before it leaves
  a_read_latched: assert property (@(posedge clk) disable iff (rst)
    pend_wait == WAIT_W'(1) |=> pend_valid && pend_wait == '0)
    else $error("read result lost");

endmodule
